### sv/mp_pkg.sv
// ----------------------------------------------------------------------------
// mp_pkg: shared types and constants for the max pooling block
// Divider stage record, register indexes, size clamps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package mp_pkg;

	localparam int KMAX = 8;          // rows kept in the row store
	localparam int QW   = 11;         // numerator / quotient width
	localparam int DW   = 4;          // stride (divisor) width

	localparam logic [2:0] REG_IN_HEIGHT  = 3'd0;
	localparam logic [2:0] REG_IN_WIDTH   = 3'd1;
	localparam logic [2:0] REG_OUT_HEIGHT = 3'd2;
	localparam logic [2:0] REG_OUT_WIDTH  = 3'd3;
	localparam logic [2:0] REG_KERNEL     = 3'd4;
	localparam logic [2:0] REG_STRIDE     = 3'd5;
	localparam logic [2:0] REG_PAD        = 3'd6;

	localparam logic [1:0] TAG_RLO = 2'd0;
	localparam logic [1:0] TAG_RHI = 2'd1;
	localparam logic [1:0] TAG_CLO = 2'd2;
	localparam logic [1:0] TAG_CHI = 2'd3;

	typedef struct packed {
		logic          valid;
		logic [1:0]    tag;
		logic [QW-1:0] num;
		logic [QW-1:0] quo;
		logic [DW-1:0] rem;
		logic [DW-1:0] den;
	} div_stage_t;

	function automatic logic [10:0] clamp_dim(input logic [10:0] v, input logic [10:0] maxv);
		logic [10:0] d;
		d = (v == 11'd0) ? 11'd1 : v;
		if (d > maxv)
			d = maxv;
		return d;
	endfunction

	function automatic logic [3:0] clamp_k(input logic [3:0] v);
		logic [3:0] k;
		k = (v == 4'd0) ? 4'd1 : v;
		if (k > 4'(KMAX))
			k = 4'(KMAX);
		return k;
	endfunction

	function automatic logic [3:0] clamp_s(input logic [3:0] v);
		return (v == 4'd0) ? 4'd1 : v;
	endfunction

endpackage
`default_nettype wire

### sv/mp_if.sv
// ----------------------------------------------------------------------------
// mp_in_if / mp_out_if: valid/ready channels of the pooling block
// Pixel items in, window result items out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface mp_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] pixel;
	modport source (output valid, output pixel, input ready);
	modport sink (input valid, input pixel, output ready);
endinterface

interface mp_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] max_value;
	logic [9:0]         out_row;
	logic [9:0]         out_col;
	logic               last;
	modport source (output valid, output max_value, output out_row, output out_col,
		output last, input ready);
	modport sink (input valid, input max_value, input out_row, input out_col,
		input last, output ready);
endinterface
`default_nettype wire

### sv/max_pool_2d_zero_pad.sv
// ----------------------------------------------------------------------------
// max_pool_2d_zero_pad: streaming 2-D max pooling with zero padding
// Raster pixel stream in, pooled window maxima with coordinates out.
// ----------------------------------------------------------------------------
// Usage:
//  - pix carries one signed Q8.8 pixel per item, raster order, planes back to
//    back. win carries results: max, output row/col, last-of-pixel mark.
//  - cfg_we/cfg_index/cfg_data write the seven size registers; write only
//    while idle.
//  - One pixel at a time. Per pixel: an accept, four issues (S_ISSUE) into an
//    11-cell divider chain (one cell per quotient bit), a wait (S_WAIT) until the
//    last quotient lands and a range check (S_CHECK), then the next pix.ready
//    when the pixel closes no window. Each window then takes kh*kw store reads
//    (one memory port, one read a cycle), then a finish step (S_FIN) and
//    the output handshake (S_EMIT).
//  - pix.ready is high only between pixels; it stays low while a result
//    waits in the output register, so a stalled receiver stalls the input.
//  - Reset clears counters, configuration registers and handshake state. The row store is
//    not cleared; every unmasked read hits an entry written earlier in the plane.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module max_pool_2d_zero_pad
	import mp_pkg::*;
#(
	parameter int MAX_WIDTH = 1024
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        cfg_we,
	input  wire  [2:0] cfg_index,
	input  wire [10:0] cfg_data,
	mp_in_if.sink      pix,
	mp_out_if.source   win
);
	localparam int DEPTH = MAX_WIDTH * KMAX;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int WMAX  = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;

	typedef enum logic [2:0] {
		S_IDLE, S_ISSUE, S_WAIT, S_CHECK, S_SCAN, S_FIN, S_EMIT
	} state_t;

	state_t state_q;

	// configuration registers
	logic [10:0] in_height_q, in_width_q, out_height_q, out_width_q;
	logic [7:0]  kernel_q, stride_q;
	logic [6:0]  pad_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_height_q  <= 11'd1;
			in_width_q   <= 11'd1;
			out_height_q <= 11'd1;
			out_width_q  <= 11'd1;
			kernel_q     <= 8'h11;
			stride_q     <= 8'h11;
			pad_q        <= 7'h00;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_IN_HEIGHT:  in_height_q  <= cfg_data;
				REG_IN_WIDTH:   in_width_q   <= cfg_data;
				REG_OUT_HEIGHT: out_height_q <= cfg_data;
				REG_OUT_WIDTH:  out_width_q  <= cfg_data;
				REG_KERNEL:     kernel_q     <= cfg_data[7:0];
				REG_STRIDE:     stride_q     <= cfg_data[7:0];
				REG_PAD:        pad_q        <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// effective sizes
	logic [10:0] h, w, oh, ow;
	logic [3:0]  kh, kw, sv, sh;
	logic [2:0]  pt, pl;

	always_comb begin
		h  = clamp_dim(in_height_q, 11'd1024);
		w  = clamp_dim(in_width_q, 11'(WMAX));
		oh = clamp_dim(out_height_q, 11'd1024);
		ow = clamp_dim(out_width_q, 11'd1024);
		kh = clamp_k(kernel_q[7:4]);
		kw = clamp_k(kernel_q[3:0]);
		sv = clamp_s(stride_q[7:4]);
		sh = clamp_s(stride_q[3:0]);
		pt = pad_q[6:4];
		pl = pad_q[2:0];
	end

	// input position; wraps to a new plane when sizes shrank
	logic [9:0] rc_q, cc_q, cur_r_q, cur_c_q;
	logic [9:0] r_eff, c_eff;
	logic       wrap;
	logic       acc_in;

	assign acc_in    = pix.valid && pix.ready;
	assign pix.ready = (state_q == S_IDLE);
	assign wrap      = ({1'b0, rc_q} >= h) || ({1'b0, cc_q} >= w);
	assign r_eff     = wrap ? 10'd0 : rc_q;
	assign c_eff     = wrap ? 10'd0 : cc_q;

	// window range numerators per axis
	logic signed [11:0] lo_t_r, hi_t_r, lo_t_c, hi_t_c;
	logic [QW-1:0]      num_rlo, num_rhi, num_clo, num_chi;

	always_comb begin
		lo_t_r = 12'(cur_r_q) + 12'(pt) + 12'sd1 - 12'(kh);
		hi_t_r = ({1'b0, cur_r_q} == h - 11'd1) ? 12'(cur_r_q) + 12'(pt) : lo_t_r;
		lo_t_c = 12'(cur_c_q) + 12'(pl) + 12'sd1 - 12'(kw);
		hi_t_c = ({1'b0, cur_c_q} == w - 11'd1) ? 12'(cur_c_q) + 12'(pl) : lo_t_c;
		num_rlo = (lo_t_r[11] ? 11'd0 : lo_t_r[10:0]) + 11'(sv) - 11'd1;
		num_rhi = hi_t_r[11] ? 11'd0 : hi_t_r[10:0];
		num_clo = (lo_t_c[11] ? 11'd0 : lo_t_c[10:0]) + 11'(sh) - 11'd1;
		num_chi = hi_t_c[11] ? 11'd0 : hi_t_c[10:0];
	end

	// divider chain: one cell per quotient bit
	div_stage_t    chain [QW+1];
	logic [1:0]    issue_q;

	always_comb begin
		chain[0].valid = (state_q == S_ISSUE);
		chain[0].tag   = issue_q;
		chain[0].quo   = '0;
		chain[0].rem   = '0;
		case (issue_q)
			TAG_RLO: begin chain[0].num = num_rlo; chain[0].den = sv; end
			TAG_RHI: begin chain[0].num = num_rhi; chain[0].den = sv; end
			TAG_CLO: begin chain[0].num = num_clo; chain[0].den = sh; end
			default: begin chain[0].num = num_chi; chain[0].den = sh; end
		endcase
	end

	for (genvar g = 0; g < QW; g++) begin : g_div
		mp_div_cell u_cell (.clk(clk), .arst_n(arst_n), .d(chain[g]), .q(chain[g+1]));
	end

	// window scan
	logic [QW-1:0]      rlo_q, rhi_q, clo_q, chi_q;
	logic [QW-1:0]      rhi_cl, chi_cl;
	logic [2:0]         got_q;
	logic [9:0]         orow_q, ocol_q;
	logic [2:0]         ii_q, jj_q;
	logic signed [14:0] r0, c0, ei, ej;
	logic               inimg;
	logic [AW-1:0]      raddr, waddr;
	logic               v_s1, first_s1, inimg_s1;
	logic signed [15:0] rdata_q, best_q, v_rd, cand;
	logic               win_ok;
	logic               last_win;

	always_comb begin
		rhi_cl = (rhi_q > oh - 11'd1) ? oh - 11'd1 : rhi_q;
		chi_cl = (chi_q > ow - 11'd1) ? ow - 11'd1 : chi_q;
		win_ok = !hi_t_r[11] && !hi_t_c[11] && (rlo_q <= rhi_cl) && (clo_q <= chi_cl);
		r0 = 15'(orow_q) * 15'(sv) - 15'(pt);
		c0 = 15'(ocol_q) * 15'(sh) - 15'(pl);
		ei = r0 + 15'(ii_q);
		ej = c0 + 15'(jj_q);
		inimg = !ei[14] && !ej[14] && (ei < 15'(h)) && (ej < 15'(w));
		raddr = AW'(ei[2:0]) * AW'(MAX_WIDTH) + AW'(ej[10:0]);
		waddr = AW'(r_eff[2:0]) * AW'(MAX_WIDTH) + AW'(c_eff);
		v_rd  = inimg_s1 ? rdata_q : 16'sd0;
		cand  = (first_s1 || v_rd > best_q) ? v_rd : best_q;
		last_win = (orow_q == rhi_q[9:0]) && (ocol_q == chi_q[9:0]);
	end

	// row store
	logic signed [15:0] store_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (acc_in)
			store_mem[waddr] <= pix.pixel;
		if (state_q == S_SCAN)
			rdata_q <= store_mem[raddr];
	end

	always_ff @(posedge clk) begin
		first_s1 <= (ii_q == 3'd0) && (jj_q == 3'd0);
		inimg_s1 <= inimg;
		if (v_s1 && state_q == S_SCAN)
			best_q <= cand;
		if (chain[QW].valid) begin
			case (chain[QW].tag)
				TAG_RLO: rlo_q <= chain[QW].quo;
				TAG_RHI: rhi_q <= chain[QW].quo;
				TAG_CLO: clo_q <= chain[QW].quo;
				default: chi_q <= chain[QW].quo;
			endcase
		end
		if (state_q == S_CHECK) begin
			rhi_q <= rhi_cl;
			chi_q <= chi_cl;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			rc_q          <= '0;
			cc_q          <= '0;
			cur_r_q       <= '0;
			cur_c_q       <= '0;
			issue_q       <= '0;
			got_q         <= '0;
			orow_q        <= '0;
			ocol_q        <= '0;
			ii_q          <= '0;
			jj_q          <= '0;
			v_s1          <= 1'b0;
			win.valid     <= 1'b0;
			win.max_value <= '0;
			win.out_row   <= '0;
			win.out_col   <= '0;
			win.last      <= 1'b0;
		end else begin
			v_s1 <= (state_q == S_SCAN);
			if (chain[QW].valid)
				got_q <= got_q + 3'd1;
			unique case (state_q)
				S_IDLE: begin
					if (acc_in) begin
						cur_r_q <= r_eff;
						cur_c_q <= c_eff;
						if ({1'b0, c_eff} + 11'd1 >= w) begin
							cc_q <= '0;
							rc_q <= ({1'b0, r_eff} + 11'd1 >= h) ? 10'd0 : r_eff + 10'd1;
						end else begin
							cc_q <= c_eff + 10'd1;
							rc_q <= r_eff;
						end
						issue_q <= TAG_RLO;
						got_q   <= '0;
						state_q <= S_ISSUE;
					end
				end
				S_ISSUE: begin
					issue_q <= issue_q + 2'd1;
					if (issue_q == TAG_CHI)
						state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (got_q == 3'd4)
						state_q <= S_CHECK;
				end
				S_CHECK: begin
					orow_q <= rlo_q[9:0];
					ocol_q <= clo_q[9:0];
					ii_q   <= '0;
					jj_q   <= '0;
					state_q <= win_ok ? S_SCAN : S_IDLE;
				end
				S_SCAN: begin
					if (4'(jj_q) == kw - 4'd1) begin
						jj_q <= '0;
						ii_q <= ii_q + 3'd1;
						if (4'(ii_q) == kh - 4'd1)
							state_q <= S_FIN;
					end else begin
						jj_q <= jj_q + 3'd1;
					end
				end
				S_FIN: begin
					win.valid     <= 1'b1;
					win.max_value <= cand;
					win.out_row   <= orow_q;
					win.out_col   <= ocol_q;
					win.last      <= last_win;
					state_q       <= S_EMIT;
				end
				S_EMIT: begin
					if (win.ready) begin
						win.valid <= 1'b0;
						ii_q      <= '0;
						jj_q      <= '0;
						if (win.last) begin
							state_q <= S_IDLE;
						end else begin
							if (ocol_q == chi_q[9:0]) begin
								ocol_q <= clo_q[9:0];
								orow_q <= orow_q + 10'd1;
							end else begin
								ocol_q <= ocol_q + 10'd1;
							end
							state_q <= S_SCAN;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

### sv/mp_div_cell.sv
// ----------------------------------------------------------------------------
// mp_div_cell: one restoring division step
// Produces one quotient bit and hands the record to the next cell.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module mp_div_cell
	import mp_pkg::*;
(
	input  wire        clk,
	input  wire        arst_n,
	input  div_stage_t d,
	output div_stage_t q
);
	logic [DW:0] rem_sh;
	logic        qbit;
	logic [DW:0] rem_nx;

	always_comb begin
		rem_sh = {d.rem, d.num[QW-1]};
		qbit   = (rem_sh >= {1'b0, d.den});
		rem_nx = qbit ? rem_sh - {1'b0, d.den} : rem_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q <= '0;
		end else begin
			q.valid <= d.valid;
			q.tag   <= d.tag;
			q.num   <= {d.num[QW-2:0], 1'b0};
			q.quo   <= {d.quo[QW-2:0], qbit};
			q.rem   <= rem_nx[DW-1:0];
			q.den   <= d.den;
		end
	end
endmodule
`default_nettype wire

### sv/mp_checker.sv
// ----------------------------------------------------------------------------
// mp_checker: port-level checks for the pooling block
// Attached to the top level by bind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module mp_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        in_valid,
	input wire        in_ready,
	input wire        out_valid,
	input wire        out_ready,
	input wire [15:0] out_max,
	input wire        out_last
);
	// a waiting result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_max) && $stable(out_last))
		else $error("stalled result changed");

	// no pixel taken while a result is pending
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input ready while result pending");

	// an accepted pixel closes the input for the next cycle
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second pixel accepted back to back");
endmodule

bind max_pool_2d_zero_pad mp_checker u_mp_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(pix.valid),
	.in_ready(pix.ready),
	.out_valid(win.valid),
	.out_ready(win.ready),
	.out_max(win.max_value),
	.out_last(win.last)
);
`default_nettype wire
